// ----- sv/srm_pkg.sv -----
// Shared types and constants of the quiet-run marker block.
// No dependencies; every other file imports this package.
package srm_pkg;

	localparam int SAMPLE_BITS       = 24;
	localparam int POSITION_BITS_DEF = 32;
	localparam int THRESH_W          = 24;
	localparam int MINLEN_W          = 32;
	localparam int POS_OUT_W         = 32;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 32;
	localparam int QUEUE_DEPTH_DEF   = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUIET_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEPARATE_TYPES   = 2'd2;

	// marker kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STOP  = 1'b1;

	// bits of the per-item marker mask, in emission order
	localparam int MK_OPEN     = 0;
	localparam int MK_RUN_END  = 1;
	localparam int MK_RUN_HEAD = 2;
	localparam int MK_FINAL    = 3;
	localparam int MK_N        = 4;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last_sample;
	} in_item_t;

	typedef struct packed {
		logic [POS_OUT_W-1:0] marker_position;
		logic                 marker_kind;
		logic                 last_of_run;
	} out_item_t;

	// markers one item causes, as queued between front and back
	typedef struct packed {
		logic [MK_N-1:0]      mask;
		logic [POS_OUT_W-1:0] end_pos;
		logic [POS_OUT_W-1:0] start_pos;
		logic [POS_OUT_W-1:0] item_pos;
		logic                 final_kind;
	} marker_rec_t;

endpackage

// ----- sv/srm_front.sv -----
// Front end: takes samples, tracks position and quiet runs, builds marker records.
// Depends on srm_pkg.
module srm_front #(
	parameter int POSITION_BITS = srm_pkg::POSITION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  srm_pkg::in_item_t             in_item,
	input  logic [srm_pkg::THRESH_W-1:0]  level_threshold,
	input  logic [srm_pkg::MINLEN_W-1:0]  min_quiet_length,
	input  logic                          separate_types,
	input  logic                          queue_full,
	output logic                          push,
	output srm_pkg::marker_rec_t          push_rec
);
	import srm_pkg::*;

	localparam int LEN_W = (POSITION_BITS > MINLEN_W) ? POSITION_BITS : MINLEN_W;

	logic                     adv;
	logic                     vld_s1;
	in_item_t                 item_s1;
	logic                     vld_s2;
	logic [POSITION_BITS-1:0] p_s2, end_s2, start_s2;
	logic                     close_s2, last_s2, first_s2;

	logic [POSITION_BITS-1:0] pos_q, run_start_q;
	logic                     in_run_q;

	logic [SAMPLE_BITS-1:0]   raw, mag;
	logic                     quiet;
	logic [POSITION_BITS-1:0] pos_inc;
	logic                     close_now;
	logic [POSITION_BITS-1:0] end_now, start_now;
	logic [POSITION_BITS-1:0] len;
	logic                     long_run;
	logic [MK_N-1:0]          mask;

	// stage 1: classify the sample, close runs
	assign raw       = item_s1.sample;
	assign mag       = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
	assign quiet     = mag < level_threshold;
	assign pos_inc   = (&pos_q) ? pos_q : pos_q + 1'b1;
	assign close_now = (!quiet && in_run_q) || (quiet && item_s1.last_sample);
	assign end_now   = quiet ? pos_inc : pos_q;
	assign start_now = in_run_q ? run_start_q : pos_q;

	// stage 2: length check and record
	assign len      = end_s2 - start_s2;
	assign long_run = LEN_W'(len) > LEN_W'(min_quiet_length);

	always_comb begin
		mask              = '0;
		mask[MK_OPEN]     = first_s2;
		mask[MK_RUN_END]  = close_s2 && long_run;
		mask[MK_RUN_HEAD] = close_s2 && long_run && separate_types;
		mask[MK_FINAL]    = last_s2;
	end

	assign adv      = !(vld_s2 && (|mask) && queue_full);
	assign in_stall = !adv;
	assign push     = vld_s2 && (|mask) && !queue_full;

	always_comb begin
		push_rec            = '0;
		push_rec.mask       = mask;
		push_rec.end_pos    = POS_OUT_W'(end_s2);
		push_rec.start_pos  = POS_OUT_W'(start_s2);
		push_rec.item_pos   = POS_OUT_W'(p_s2);
		push_rec.final_kind = separate_types ? KIND_STOP : KIND_START;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			pos_q       <= '0;
			in_run_q    <= 1'b0;
			run_start_q <= '0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				if (item_s1.last_sample) begin
					pos_q       <= '0;
					in_run_q    <= 1'b0;
					run_start_q <= '0;
				end else begin
					pos_q <= pos_inc;
					if (quiet && !in_run_q) begin
						in_run_q    <= 1'b1;
						run_start_q <= pos_q;
					end else if (!quiet) begin
						in_run_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1  <= in_item;
			p_s2     <= pos_q;
			end_s2   <= end_now;
			start_s2 <= start_now;
			close_s2 <= close_now;
			last_s2  <= item_s1.last_sample;
			first_s2 <= (pos_q == '0);
		end
	end

endmodule

// ----- sv/srm_queue.sv -----
// Short queue of marker records between front and back end.
// Depends on srm_pkg.
module srm_queue #(
	parameter int DEPTH = srm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  srm_pkg::marker_rec_t push_rec,
	input  logic                 pop,
	output srm_pkg::marker_rec_t head_rec,
	output logic                 full,
	output logic                 empty
);
	import srm_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	marker_rec_t      mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_rec = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/srm_back.sv -----
// Back end: unpacks queued records into single markers, one per cycle unless the output stalls.
// Depends on srm_pkg.
module srm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srm_pkg::marker_rec_t head_rec,
	input  logic                 empty,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output srm_pkg::out_item_t   out_item
);
	import srm_pkg::*;

	marker_rec_t     cur_q;
	logic            cur_vld_q;
	logic            out_vld_q;
	out_item_t       out_q;
	logic            emit;
	logic [MK_N-1:0] rest;
	out_item_t       nxt;

	// lowest pending marker goes first
	always_comb begin
		nxt  = '0;
		rest = cur_q.mask;
		if (cur_q.mask[MK_OPEN]) begin
			nxt.marker_position = '0;
			nxt.marker_kind     = KIND_START;
			rest[MK_OPEN]       = 1'b0;
		end else if (cur_q.mask[MK_RUN_END]) begin
			nxt.marker_position = cur_q.end_pos;
			nxt.marker_kind     = KIND_START;
			rest[MK_RUN_END]    = 1'b0;
		end else if (cur_q.mask[MK_RUN_HEAD]) begin
			nxt.marker_position = cur_q.start_pos;
			nxt.marker_kind     = KIND_STOP;
			rest[MK_RUN_HEAD]   = 1'b0;
		end else begin
			nxt.marker_position = cur_q.item_pos;
			nxt.marker_kind     = cur_q.final_kind;
			rest[MK_FINAL]      = 1'b0;
		end
		nxt.last_of_run = (rest == '0);
	end

	assign emit = cur_vld_q && (!out_vld_q || !out_stall);
	assign pop  = !empty && (!cur_vld_q || (emit && rest == '0));

	assign out_valid = out_vld_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || !out_stall) begin
				out_vld_q <= cur_vld_q;
			end
			if (pop) begin
				cur_vld_q <= 1'b1;
			end else if (emit && rest == '0) begin
				cur_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= nxt;
		end
		if (pop) begin
			cur_q <= head_rec;
		end else if (emit) begin
			cur_q.mask <= rest;
		end
	end

endmodule

// ----- sv/silence_run_marker.sv -----
// Top level of the quiet-run marker block: configuration registers and the
// front end, record queue and back end. Depends on srm_pkg, srm_front,
// srm_queue and srm_back.
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   in_item (sample, last_sample)
//   out       output     out_valid/out_stall out_item (position, kind, last_of_run)
//   cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One sample is taken every cycle while in_stall is low; it passes the stage 1 and
// stage 2 registers before it reaches the record queue. The back end unpacks each record
// into markers one by one; a sample causes up to four, and the queue absorbs bursts.
// The queue holds four records by default; markers then leave via cur_q and out_q.
// Reset clears position, run state and all valid flags; registers take their reset values.
// in_stall rises only when a record is waiting and the queue is full.
module silence_run_marker #(
	parameter int POSITION_BITS = srm_pkg::POSITION_BITS_DEF,
	parameter int QUEUE_DEPTH   = srm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  srm_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output srm_pkg::out_item_t             out_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [srm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import srm_pkg::*;

	logic [THRESH_W-1:0] level_threshold_q;
	logic [MINLEN_W-1:0] min_quiet_length_q;
	logic                separate_types_q;

	logic        push, pop, full, empty;
	marker_rec_t push_rec, head_rec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_threshold_q  <= '0;
			min_quiet_length_q <= '0;
			separate_types_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEVEL_THRESHOLD: begin
					level_threshold_q <= cfg_data[THRESH_W-1:0];
				end
				CFG_MIN_QUIET_LENGTH: begin
					min_quiet_length_q <= cfg_data[MINLEN_W-1:0];
				end
				CFG_SEPARATE_TYPES: begin
					separate_types_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	srm_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_item         (in_item),
		.level_threshold (level_threshold_q),
		.min_quiet_length(min_quiet_length_q),
		.separate_types  (separate_types_q),
		.queue_full      (full),
		.push            (push),
		.push_rec        (push_rec)
	);

	srm_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.pop     (pop),
		.head_rec(head_rec),
		.full    (full),
		.empty   (empty)
	);

	srm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_rec (head_rec),
		.empty    (empty),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

endmodule

// ----- sv/srm_checker.sv -----
// Port-level checks on the quiet-run marker block, bound to the top level.
// Depends on srm_pkg and silence_run_marker.
module srm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input srm_pkg::out_item_t out_item,
	input logic               cfg_valid,
	input logic               cfg_ready
);
	import srm_pkg::*;

	// a stalled marker holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("marker changed while stalled");

	// markers of one item leave on consecutive cycles
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_item.last_of_run |=> out_valid)
		else $error("gap inside the markers of one item");

	// a stop-kind marker that is not the last is a run head, so a final one follows
	a_head_then_more: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_item.marker_kind == KIND_STOP && !out_item.last_of_run
		|=> out_valid && out_item.last_of_run)
		else $error("run-head marker not followed by final marker");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

	// the output flag is cleared asynchronously by reset and stays low through it
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind silence_run_marker srm_checker u_srm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_item (out_item),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

// ----- test/tb_silence_run_marker.sv -----
// Testbench of silence_run_marker: a directed table, then random signals under several
// idle and stall patterns. Every marker is checked against typed rows or a local predictor.
// Depends on srm_pkg and the silence_run_marker RTL.
module tb_silence_run_marker;
	timeunit 1ns;
	timeprecision 1ps;
	import srm_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE      = 16;
	localparam int SHOWN_MAX   = 10;
	localparam int HOLD_CYCLES = 80;
	localparam int MAG_TOP     = 8388608;
	localparam int PHASE_MIN   = 40;
	localparam logic [THRESH_W-1:0] THR_TOP = 24'h800000;
	localparam logic [MINLEN_W-1:0] LEN_TOP = '1;
	localparam out_item_t NO_MARK = '0;
	localparam in_item_t  NO_ITEM = '0;

	typedef enum logic {ROW_SETUP, ROW_SAMPLE} row_kind_e;

	// n_typed < 0: expectation comes from the predictor
	typedef struct {
		row_kind_e           kind;
		logic [THRESH_W-1:0] thr_cfg;
		logic [MINLEN_W-1:0] len_cfg;
		logic                sep_cfg;
		in_item_t            item;
		int                  n_typed;
		out_item_t           typed_a;
		out_item_t           typed_b;
	} stim_row_t;

	localparam int PLAN_ROWS = 27;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_LEVEL_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor copy of registers and run state
	logic [THRESH_W-1:0]  level_thr;
	logic [MINLEN_W-1:0]  min_len;
	logic                 split_kinds;
	logic [POS_OUT_W-1:0] next_pos;
	logic [POS_OUT_W-1:0] run_head;
	logic                 run_open;
	out_item_t            step_marks [MK_N];
	int                   step_count;
	out_item_t            marker_q [$];

	int error_count = 0;
	int cycle_count = 0;
	int idle_pct    = 0;
	int stall_pct   = 0;
	int hold_asked  = 0;
	int hold_done   = 0;
	int hold_left   = 0;
	int phase_items = 0;

	stim_row_t plan [PLAN_ROWS] = '{
		// reset values: nothing is quiet, kinds kept apart
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'h000000, 1'b1}, 2,
			'{32'd0, KIND_START, 1'b0}, '{32'd0, KIND_STOP, 1'b1}},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'h7FFFFF, 1'b0}, 1,
			'{32'd0, KIND_START, 1'b1}, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'h800000, 1'b0}, 0, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'h000001, 1'b1}, 1,
			'{32'd2, KIND_STOP, 1'b1}, NO_MARK},
		// top threshold: all quiet but the most negative sample
		'{ROW_SETUP, THR_TOP, 32'd0, 1'b1, NO_ITEM, 0, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'h800000, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'h7FFFFF, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'h800001, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'h800000, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'h000000, 1'b1}, -1, NO_MARK, NO_MARK},
		// runs can never be long enough, single kind
		'{ROW_SETUP, 24'd100, LEN_TOP, 1'b0, NO_ITEM, 0, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'd99, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'hFFFF9D, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'hFFFF9C, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'd0, 1'b1}, -1, NO_MARK, NO_MARK},
		// length boundary: a run of two is too short, three is enough
		'{ROW_SETUP, 24'd1, 32'd2, 1'b0, NO_ITEM, 0, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'd0, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'd0, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'd0, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'd0, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'd1, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'd0, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'd0, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'hFFFFFF, 1'b1}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'd0, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'd0, 1'b0}, -1, NO_MARK, NO_MARK},
		'{ROW_SAMPLE, 24'd0, 32'd0, 1'b0, '{24'd0, 1'b1}, -1, NO_MARK, NO_MARK}
	};

	silence_run_marker uut (.*);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	function automatic void add_marker(logic [POS_OUT_W-1:0] pos, logic kind);
		step_marks[step_count] = '{pos, kind, 1'b0};
		step_count++;
	endfunction

	function automatic void close_run(logic [POS_OUT_W-1:0] end_pos);
		if (end_pos - run_head > min_len) begin
			add_marker(end_pos, KIND_START);
			if (split_kinds)
				add_marker(run_head, KIND_STOP);
		end
		run_open = 1'b0;
	endfunction

	function automatic void predict_markers(in_item_t it);
		logic [POS_OUT_W-1:0] p;
		logic [THRESH_W-1:0]  mag;
		p = next_pos;
		step_count = 0;
		mag = it.sample[SAMPLE_BITS-1] ? -it.sample : it.sample;
		if (p == '0)
			add_marker('0, KIND_START);
		if (mag < level_thr) begin
			if (!run_open) begin
				run_open = 1'b1;
				run_head = p;
			end
		end else if (run_open) begin
			close_run(p);
		end
		if (it.last_sample) begin
			// an open run ends one past the last sample, saturated
			if (run_open)
				close_run((p == '1) ? p : p + 1);
			add_marker(p, split_kinds ? KIND_STOP : KIND_START);
			next_pos = '0;
			run_head = '0;
			run_open = 1'b0;
		end else if (p != '1) begin
			next_pos = p + 1;
		end
		if (step_count > 0)
			step_marks[step_count-1].last_of_run = 1'b1;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] draw_sample(logic want_quiet);
		int mag;
		if ($urandom_range(9) == 0)
			return SAMPLE_BITS'($urandom);
		if (want_quiet && level_thr != '0) begin
			mag = $urandom_range(int'(level_thr) - 1, 0);
		end else begin
			mag = $urandom_range(MAG_TOP, int'(level_thr));
			if (mag == MAG_TOP)
				return 24'h800000;
		end
		return $urandom_range(1) ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
	endfunction

	function automatic void note_fault(string what, out_item_t want, out_item_t got);
		error_count++;
		if (error_count <= SHOWN_MAX)
			$display("%0t %s: expected pos %0d kind %0b last %0b, got pos %0d kind %0b last %0b",
				$time, what, want.marker_position, want.marker_kind, want.last_of_run,
				got.marker_position, got.marker_kind, got.last_of_run);
	endfunction

	task automatic write_settings(logic [THRESH_W-1:0] thr, logic [MINLEN_W-1:0] len,
			logic sep);
		logic [CFG_IDX_W-1:0]  idx  [3];
		logic [CFG_DATA_W-1:0] vals [3];
		idx  = '{CFG_LEVEL_THRESHOLD, CFG_MIN_QUIET_LENGTH, CFG_SEPARATE_TYPES};
		vals = '{CFG_DATA_W'(thr), CFG_DATA_W'(len), CFG_DATA_W'(sep)};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid   <= 1'b0;
		level_thr   = thr;
		min_len     = len;
		split_kinds = sep;
	endtask

	task automatic send_sample(in_item_t it, int n_typed, out_item_t ta, out_item_t tb);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		predict_markers(it);
		if (n_typed < 0) begin
			for (int i = 0; i < step_count; i++)
				marker_q.push_back(step_marks[i]);
		end else begin
			if (n_typed > 0)
				marker_q.push_back(ta);
			if (n_typed > 1)
				marker_q.push_back(tb);
		end
	endtask

	// one signal of alternating quiet and loud runs, lengths around the minimum when it is below eight
	task automatic send_signal(int max_len);
		int       len;
		int       run;
		logic     quiet;
		in_item_t it;
		len   = $urandom_range(max_len, 1);
		quiet = 1'($urandom_range(1));
		run   = 0;
		for (int k = 0; k < len; k++) begin
			if (run == 0) begin
				quiet = ~quiet;
				run = (min_len < 8) ? $urandom_range(int'(min_len) + 3, 1) : $urandom_range(12, 1);
			end
			run--;
			it.sample      = draw_sample(quiet);
			it.last_sample = (k == len - 1);
			send_sample(it, -1, NO_MARK, NO_MARK);
		end
		phase_items += len;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (marker_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// receiver: random stalls, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_done < hold_asked) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= hold_done + 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (marker_q.size() == 0) begin
				note_fault("marker with none pending", NO_MARK, out_item);
			end else begin
				want = marker_q.pop_front();
				if (want.marker_position !== out_item.marker_position ||
						want.marker_kind !== out_item.marker_kind ||
						want.last_of_run !== out_item.last_of_run)
					note_fault("marker mismatch", want, out_item);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [THRESH_W-1:0] thr_v;
		logic [MINLEN_W-1:0] len_v;
		level_thr   = '0;
		min_len     = '0;
		split_kinds = 1'b1;
		next_pos    = '0;
		run_head    = '0;
		run_open    = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_SETUP) begin
				drain();
				write_settings(plan[r].thr_cfg, plan[r].len_cfg, plan[r].sep_cfg);
			end else begin
				send_sample(plan[r].item, plan[r].n_typed, plan[r].typed_a, plan[r].typed_b);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case ($urandom_range(5))
				0:       thr_v = '0;
				1:       thr_v = THR_TOP;
				2, 3:    thr_v = THRESH_W'($urandom_range(64, 1));
				default: thr_v = THRESH_W'($urandom_range(MAG_TOP, 1));
			endcase
			case ($urandom_range(5))
				0:       len_v = '0;
				1:       len_v = LEN_TOP;
				default: len_v = MINLEN_W'($urandom_range(6, 0));
			endcase
			write_settings(thr_v, len_v, 1'($urandom_range(1)));
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 82; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 82; end
				default: begin idle_pct = 30; stall_pct = 30; end
			endcase
			// long hold-off with the sender flat out and short signals
			if (ph == 4)
				hold_asked++;
			phase_items = 0;
			while (phase_items < PHASE_MIN)
				send_signal((ph == 4) ? 3 : (($urandom_range(7) == 0) ? 90 : 24));
		end
		drain();

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/srm_pkg.sv
sv/srm_front.sv
sv/srm_queue.sv
sv/srm_back.sv
sv/silence_run_marker.sv
sv/srm_checker.sv
test/tb_silence_run_marker.sv
